### sv/cxalu_pkg.sv
`default_nettype none
package cxalu_pkg;

   localparam logic [2:0] MODE_LOAD = 3'd0;
   localparam logic [2:0] MODE_ADD  = 3'd1;
   localparam logic [2:0] MODE_SUB  = 3'd2;
   localparam logic [2:0] MODE_MUL  = 3'd3;
   localparam logic [2:0] MODE_DIV  = 3'd4;
   localparam logic [2:0] MODE_MAG  = 3'd5;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_DIVZERO = 2'd1;
   localparam logic [1:0] STAT_SAT     = 2'd2;

   localparam int DIV_STEPS  = 80;
   localparam int SQRT_STEPS = 32;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PROD = 6'b000010,
      ST_POST = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_SQRT = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      TGT_A = 2'd0,
      TGT_B = 2'd1,
      TGT_D = 2'd2
   } target_type;

   // {saturated, value}
   function automatic logic [32:0] sat_pack(input logic neg, input logic [63:0] mag);
      logic [32:0] r;
      if (neg) begin
         if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
         else r = {1'b0, 32'(~mag[31:0] + 32'd1)};
      end else begin
         if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else r = {1'b0, mag[31:0]};
      end
      return r;
   endfunction

   function automatic logic [32:0] sat_small(input logic signed [32:0] s);
      logic [32:0] r;
      if (s > 33'sh0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else if (s < -33'sh0_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, s[31:0]};
      return r;
   endfunction

   // sign of a wrapped sum whose true value lies in (-2^63, 2^63]
   function automatic logic wrap_neg(input logic [63:0] w);
      return w[63] && (w != 64'h8000_0000_0000_0000);
   endfunction

   function automatic logic [63:0] wrap_mag(input logic [63:0] w);
      return wrap_neg(w) ? (~w + 64'd1) : w;
   endfunction

   // floor(w / 2^16), saturated
   function automatic logic [32:0] mul_part(input logic [63:0] w);
      logic        n;
      logic [63:0] m;
      n = wrap_neg(w);
      m = wrap_mag(w);
      if (n) m = (m + 64'h0000_0000_0000_FFFF) >> 16;
      else m = m >> 16;
      return sat_pack(n, m);
   endfunction

endpackage
`default_nettype wire

### sv/cxalu_if.sv
`default_nettype none
interface cxalu_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic signed [31:0] operand_real;
   logic signed [31:0] operand_imag;
   modport source (output valid, mode, operand_real, operand_imag, input ready);
   modport sink   (input valid, mode, operand_real, operand_imag, output ready);
endinterface

interface cxalu_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] result_real;
   logic signed [31:0] result_imag;
   logic [31:0] modulus;
   logic [1:0]  status;
   modport source (output valid, result_real, result_imag, modulus, status, input ready);
   modport sink   (input valid, result_real, result_imag, modulus, status, output ready);
endinterface
`default_nettype wire

### sv/cxalu_mult.sv
`default_nettype none
module cxalu_mult (
   input  wire logic               clock,
   input  wire logic signed [31:0] mul_a,
   input  wire logic signed [31:0] mul_b,
   output logic [63:0]             prod_ff
);
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a * mul_b);
   end
endmodule
`default_nettype wire

### sv/complex_accumulator_alu.sv
`default_nettype none
// Complex accumulator ALU, signed Q16.16, one request at a time.
// Load, add, subtract and unused modes need no products; multiply and magnitude
// run products on one multiplier; divide runs two 80-step restoring divisions on
// one shared subtractor after six products on one multiplier; divide by zero stops
// after the products. A new request is taken the cycle after the result enters the
// output register; a stalled result holds off the input.
// Synchronous reset clears the accumulator to zero and empties the output.
module complex_accumulator_alu (
   input  wire logic   clock,
   input  wire logic   reset,
   cxalu_req_if.sink   req_chan,
   cxalu_rsp_if.source rsp_chan
);
   import cxalu_pkg::*;

   state_type   state_ff;
   logic [2:0]  mode_ff;
   logic [31:0] acc_r_ff, acc_i_ff;
   logic [31:0] br_ff, bi_ff;
   logic [31:0] nr_ff, ni_ff, modv_ff;
   logic [1:0]  stat_ff;
   logic        sat_ff;
   logic [63:0] wa_ff, wb_ff, wd_ff;
   logic [63:0] rem_ff;
   logic [32:0] q_ff;
   logic        big_ff, neg_ff, part_ff;
   logic [6:0]  cnt_ff;
   logic        pvalid_ff, psub_ff;
   target_type  ptgt_ff;
   logic        rvalid_ff;
   logic [31:0] out_r_ff, out_i_ff, out_m_ff;
   logic [1:0]  out_s_ff;

   logic [31:0] op_a, op_b;
   target_type  tgt;
   logic        tsub;
   logic [2:0]  nprod;
   logic [63:0] prod;

   cxalu_mult u_mult (
      .clock   (clock),
      .mul_a   (op_a),
      .mul_b   (op_b),
      .prod_ff (prod)
   );

   // product schedule per mode
   always_comb begin
      op_a  = acc_r_ff;
      op_b  = br_ff;
      tgt   = TGT_A;
      tsub  = 1'b0;
      nprod = 3'd0;
      unique case (mode_ff)
         MODE_MUL: begin
            nprod = 3'd4;
            unique case (cnt_ff[2:0])
               3'd0: begin op_a = acc_r_ff; op_b = br_ff; end
               3'd1: begin op_a = acc_i_ff; op_b = bi_ff; tsub = 1'b1; end
               3'd2: begin op_a = acc_r_ff; op_b = bi_ff; tgt = TGT_B; end
               default: begin op_a = acc_i_ff; op_b = br_ff; tgt = TGT_B; end
            endcase
         end
         MODE_DIV: begin
            nprod = 3'd6;
            unique case (cnt_ff[2:0])
               3'd0: begin op_a = acc_r_ff; op_b = br_ff; end
               3'd1: begin op_a = acc_i_ff; op_b = bi_ff; end
               3'd2: begin op_a = acc_r_ff; op_b = bi_ff; tgt = TGT_B; tsub = 1'b1; end
               3'd3: begin op_a = acc_i_ff; op_b = br_ff; tgt = TGT_B; end
               3'd4: begin op_a = br_ff; op_b = br_ff; tgt = TGT_D; end
               default: begin op_a = bi_ff; op_b = bi_ff; tgt = TGT_D; end
            endcase
         end
         MODE_MAG: begin
            nprod = 3'd2;
            if (cnt_ff[0]) begin op_a = acc_i_ff; op_b = acc_i_ff; end
            else begin op_a = acc_r_ff; op_b = acc_r_ff; end
         end
         default: nprod = 3'd0;
      endcase
   end

   // load, add and subtract straight from the request
   logic [32:0] simp_r, simp_i;
   always_comb begin
      simp_r = {1'b0, acc_r_ff};
      simp_i = {1'b0, acc_i_ff};
      unique case (req_chan.mode)
         MODE_LOAD: begin
            simp_r = {1'b0, req_chan.operand_real};
            simp_i = {1'b0, req_chan.operand_imag};
         end
         MODE_ADD: begin
            simp_r = sat_small(33'(signed'(acc_r_ff)) + 33'(req_chan.operand_real));
            simp_i = sat_small(33'(signed'(acc_i_ff)) + 33'(req_chan.operand_imag));
         end
         MODE_SUB: begin
            simp_r = sat_small(33'(signed'(acc_r_ff)) - 33'(req_chan.operand_real));
            simp_i = sat_small(33'(signed'(acc_i_ff)) - 33'(req_chan.operand_imag));
         end
         default: ;
      endcase
   end

   logic [32:0] mul_r, mul_i;
   assign mul_r = mul_part(wa_ff);
   assign mul_i = mul_part(wb_ff);

   // one restoring division step
   logic [63:0] rp;
   logic        dge;
   logic [32:0] qn;
   logic        bign;
   logic [32:0] dpk;
   assign rp   = {rem_ff[62:0], wa_ff[63]};
   assign dge  = rp >= wd_ff;
   assign qn   = {q_ff[31:0], dge};
   assign bign = big_ff | q_ff[32];
   assign dpk  = sat_pack(neg_ff, bign ? 64'hFFFF_FFFF_FFFF_FFFF : {31'd0, qn});

   // one square root step: wa holds the radicand, wb the root, wd the bit
   logic [63:0] st;
   logic        sge;
   logic [63:0] res_n;
   assign st    = wb_ff + wd_ff;
   assign sge   = wa_ff >= st;
   assign res_n = sge ? ((wb_ff >> 1) + wd_ff) : (wb_ff >> 1);

   logic out_free;
   assign out_free       = !rvalid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid       = rvalid_ff;
   assign rsp_chan.result_real = out_r_ff;
   assign rsp_chan.result_imag = out_i_ff;
   assign rsp_chan.modulus     = out_m_ff;
   assign rsp_chan.status      = out_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
         acc_r_ff  <= '0;
         acc_i_ff  <= '0;
         pvalid_ff <= 1'b0;
      end else begin
         if (rvalid_ff && rsp_chan.ready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  mode_ff <= req_chan.mode;
                  br_ff   <= req_chan.operand_real;
                  bi_ff   <= req_chan.operand_imag;
                  wa_ff   <= '0;
                  wb_ff   <= '0;
                  wd_ff   <= '0;
                  cnt_ff  <= '0;
                  sat_ff  <= 1'b0;
                  modv_ff <= '0;
                  pvalid_ff <= 1'b0;
                  if (req_chan.mode == MODE_MUL || req_chan.mode == MODE_DIV ||
                      req_chan.mode == MODE_MAG) begin
                     state_ff <= ST_PROD;
                  end else begin
                     nr_ff    <= simp_r[31:0];
                     ni_ff    <= simp_i[31:0];
                     stat_ff  <= (simp_r[32] | simp_i[32]) ? STAT_SAT : STAT_OK;
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_PROD: begin
               if (pvalid_ff) begin
                  unique case (ptgt_ff)
                     TGT_A:   wa_ff <= psub_ff ? wa_ff - prod : wa_ff + prod;
                     TGT_B:   wb_ff <= psub_ff ? wb_ff - prod : wb_ff + prod;
                     default: wd_ff <= wd_ff + prod;
                  endcase
               end
               if (cnt_ff[2:0] < nprod) begin
                  pvalid_ff <= 1'b1;
                  ptgt_ff   <= tgt;
                  psub_ff   <= tsub;
                  cnt_ff    <= cnt_ff + 7'd1;
               end else begin
                  pvalid_ff <= 1'b0;
                  state_ff  <= ST_POST;
               end
            end
            ST_POST: begin
               nr_ff   <= acc_r_ff;
               ni_ff   <= acc_i_ff;
               stat_ff <= STAT_OK;
               cnt_ff  <= '0;
               priority if (mode_ff == MODE_MUL) begin
                  nr_ff    <= mul_r[31:0];
                  ni_ff    <= mul_i[31:0];
                  stat_ff  <= (mul_r[32] | mul_i[32]) ? STAT_SAT : STAT_OK;
                  state_ff <= ST_FIN;
               end else if (mode_ff == MODE_DIV) begin
                  if (wd_ff == '0) begin
                     stat_ff  <= STAT_DIVZERO;
                     state_ff <= ST_FIN;
                  end else begin
                     neg_ff   <= wrap_neg(wa_ff);
                     wa_ff    <= wrap_mag(wa_ff);
                     rem_ff   <= '0;
                     q_ff     <= '0;
                     big_ff   <= 1'b0;
                     part_ff  <= 1'b0;
                     state_ff <= ST_DIV;
                  end
               end else begin
                  wb_ff    <= '0;
                  wd_ff    <= 64'h4000_0000_0000_0000;
                  state_ff <= ST_SQRT;
               end
            end
            ST_DIV: begin
               rem_ff <= dge ? rp - wd_ff : rp;
               wa_ff  <= {wa_ff[62:0], 1'b0};
               q_ff   <= qn;
               big_ff <= bign;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(DIV_STEPS - 1)) begin
                  // finish this quotient; start the imaginary one or wrap up
                  sat_ff <= sat_ff | dpk[32];
                  cnt_ff <= '0;
                  rem_ff <= '0;
                  q_ff   <= '0;
                  big_ff <= 1'b0;
                  if (!part_ff) begin
                     nr_ff   <= dpk[31:0];
                     neg_ff  <= wrap_neg(wb_ff);
                     wa_ff   <= wrap_mag(wb_ff);
                     part_ff <= 1'b1;
                  end else begin
                     ni_ff    <= dpk[31:0];
                     stat_ff  <= (sat_ff | dpk[32]) ? STAT_SAT : STAT_OK;
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_SQRT: begin
               if (sge) wa_ff <= wa_ff - st;
               wb_ff  <= res_n;
               wd_ff  <= wd_ff >> 2;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(SQRT_STEPS - 1)) begin
                  modv_ff  <= res_n[31:0];
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  acc_r_ff  <= nr_ff;
                  acc_i_ff  <= ni_ff;
                  out_r_ff  <= nr_ff;
                  out_i_ff  <= ni_ff;
                  out_m_ff  <= modv_ff;
                  out_s_ff  <= stat_ff;
                  rvalid_ff <= 1'b1;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
